// File: sv/tas_pkg.sv
// shared types and command/status codes for the throttle actuator sequencer
package tas_pkg;

  localparam int KIND_BITS   = 4;
  localparam int STATUS_BITS = 3;

  localparam logic [KIND_BITS-1:0] KIND_UP           = 4'd0;
  localparam logic [KIND_BITS-1:0] KIND_DOWN         = 4'd1;
  localparam logic [KIND_BITS-1:0] KIND_RUN          = 4'd2;
  localparam logic [KIND_BITS-1:0] KIND_STOP         = 4'd3;
  localparam logic [KIND_BITS-1:0] KIND_IDLE         = 4'd4;
  localparam logic [KIND_BITS-1:0] KIND_MAX          = 4'd5;
  localparam logic [KIND_BITS-1:0] KIND_CALIBRATE    = 4'd6;
  localparam logic [KIND_BITS-1:0] KIND_ENGINE_ERROR = 4'd7;
  localparam logic [KIND_BITS-1:0] KIND_FREQ_REPORT  = 4'd8;

  localparam logic [STATUS_BITS-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_UNCAL  = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_GOAL   = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_CLOSED = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_ERROR  = 3'd4;

  typedef struct packed {
    logic calibrating;
    logic calibrated;
    logic fault;
  } tas_flags_t;

endpackage

// File: sv/tas_step.sv
// next-state and result logic for one throttle command
module tas_step import tas_pkg::*; #(
  parameter int POSITION_BITS = 13,
  parameter int FREQ_BITS     = 16
) (
  input  logic [KIND_BITS-1:0]            kind,
  input  logic [FREQ_BITS-1:0]            measured_frequency,
  input  logic [FREQ_BITS-1:0]            target_frequency,
  input  logic signed [POSITION_BITS-1:0] position,
  input  logic signed [POSITION_BITS-1:0] idle_pos,
  input  logic signed [POSITION_BITS-1:0] top_pos,
  input  tas_flags_t                      flags,
  input  logic [FREQ_BITS-1:0]            last_frequency,
  output logic signed [POSITION_BITS-1:0] position_next,
  output logic signed [POSITION_BITS-1:0] idle_pos_next,
  output logic signed [POSITION_BITS-1:0] top_pos_next,
  output tas_flags_t                      flags_next,
  output logic [FREQ_BITS-1:0]            last_frequency_next,
  output logic signed [POSITION_BITS:0]   steps_moved,
  output logic [STATUS_BITS-1:0]          status
);

  localparam int STEP_BITS = POSITION_BITS + 1;
  localparam logic signed [POSITION_BITS-1:0] POS_ZERO = '0;
  localparam logic signed [POSITION_BITS-1:0] POS_ONE  = {{(POSITION_BITS-1){1'b0}}, 1'b1};
  localparam logic signed [POSITION_BITS-1:0] POS_TOP  = {1'b0, {(POSITION_BITS-1){1'b1}}};
  localparam logic signed [POSITION_BITS-1:0] POS_BOT  = {1'b1, {(POSITION_BITS-1){1'b0}}};

  logic                            drive;  // moves and reports steps
  logic                            jump;   // moves without driving (calibration zero)
  logic signed [POSITION_BITS-1:0] dest;

  always_comb begin
    idle_pos_next       = idle_pos;
    top_pos_next        = top_pos;
    flags_next          = flags;
    last_frequency_next = last_frequency;
    status              = ST_OK;
    drive               = 1'b0;
    jump                = 1'b0;
    dest                = position;
    case (kind)
      KIND_UP: begin
        if (position != POS_TOP) begin
          drive = 1'b1;
          dest  = position + POS_ONE;
        end
      end
      KIND_DOWN: begin
        if (position != POS_BOT) begin
          drive = 1'b1;
          dest  = position - POS_ONE;
        end
      end
      KIND_RUN: begin
        if (!flags.calibrated) begin
          status = ST_UNCAL;
        end else if (target_frequency > last_frequency) begin
          if (position < top_pos) begin
            drive = 1'b1;
            dest  = position + POS_ONE;
          end else begin
            flags_next.fault = 1'b1;
            status           = ST_ERROR;
          end
        end else if (target_frequency < last_frequency) begin
          if (position > POS_ZERO) begin
            drive = 1'b1;
            dest  = position - POS_ONE;
          end else begin
            status = ST_CLOSED;
          end
        end else begin
          status = ST_GOAL;
        end
      end
      KIND_STOP, KIND_ENGINE_ERROR: begin
        if (flags.calibrating) begin
          jump = 1'b1;
          dest = POS_ZERO;
        end else if (!flags.calibrated) begin
          status = ST_UNCAL;
        end else if (position > POS_ZERO) begin
          drive = 1'b1;
          dest  = POS_ZERO;
        end
        // engine error forces the flag and its own status over the stop result
        if (kind == KIND_ENGINE_ERROR) begin
          flags_next.fault = 1'b1;
          status           = ST_ERROR;
        end
      end
      KIND_IDLE: begin
        if (flags.calibrating) begin
          idle_pos_next = position;
        end else if (flags.calibrated) begin
          drive = 1'b1;
          dest  = idle_pos;
        end else begin
          status = ST_UNCAL;
        end
      end
      KIND_MAX: begin
        if (flags.calibrating) begin
          top_pos_next           = position;
          flags_next.calibrated  = 1'b1;
          flags_next.calibrating = 1'b0;
        end else if (flags.calibrated) begin
          if (position < top_pos) begin
            drive = 1'b1;
            dest  = top_pos;
          end
        end else begin
          status = ST_UNCAL;
        end
      end
      KIND_CALIBRATE: begin
        flags_next.calibrating = 1'b1;
      end
      KIND_FREQ_REPORT: begin
        last_frequency_next = measured_frequency;
      end
      default: begin
      end
    endcase
  end

  assign position_next = (drive || jump) ? dest : position;
  assign steps_moved   = drive ? (STEP_BITS'(dest) - STEP_BITS'(position)) : '0;

endmodule

// File: sv/throttle_actuator_sequencer.sv
// throttle actuator sequencer top level: request register, command logic, result register
//
// Takes one throttle command per clock while the result side does not stall,
// and returns exactly one result per command. A request is held in an input
// register; the command logic then updates the position, learned idle/max
// positions and flags and loads the result register, so each request passes
// through the input register and then the result register, and commands may
// follow back to back at one per clock. A stall on the result side holds the
// result register and, once the input register is also full, stalls the
// request side. target_frequency is written through cfg_write_enable/cfg_write_data;
// the user writes it only while no command is in flight; the block does not enforce it.
module throttle_actuator_sequencer import tas_pkg::*; #(
  parameter int POSITION_BITS = 13,
  parameter int FREQ_BITS     = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_enable,
  input  logic [FREQ_BITS-1:0]            cfg_write_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [KIND_BITS-1:0]            kind,
  input  logic [FREQ_BITS-1:0]            measured_frequency,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [POSITION_BITS-1:0] position,
  output logic signed [POSITION_BITS:0]   steps_moved,
  output logic [STATUS_BITS-1:0]          status,
  output logic                            error_flag,
  output logic                            calibrated_flag,
  output logic                            calibrating_flag
);

  logic [FREQ_BITS-1:0]            target_frequency;
  logic signed [POSITION_BITS-1:0] position_reg;
  logic signed [POSITION_BITS-1:0] idle_reg;
  logic signed [POSITION_BITS-1:0] max_reg;
  tas_flags_t                      flags;
  logic [FREQ_BITS-1:0]            last_frequency;

  logic                            req_valid;
  logic [KIND_BITS-1:0]            req_kind;
  logic [FREQ_BITS-1:0]            req_freq;

  logic signed [POSITION_BITS-1:0] position_next;
  logic signed [POSITION_BITS-1:0] idle_next;
  logic signed [POSITION_BITS-1:0] max_next;
  tas_flags_t                      flags_next;
  logic [FREQ_BITS-1:0]            last_frequency_next;
  logic signed [POSITION_BITS:0]   steps_next;
  logic [STATUS_BITS-1:0]          status_next;

  logic advance;

  // result register can take a new result
  assign advance  = !out_valid || !out_stall;
  assign in_stall = req_valid && !advance;

  tas_step #(
    .POSITION_BITS(POSITION_BITS),
    .FREQ_BITS    (FREQ_BITS)
  ) u_step (
    .kind               (req_kind),
    .measured_frequency (req_freq),
    .target_frequency   (target_frequency),
    .position           (position_reg),
    .idle_pos           (idle_reg),
    .top_pos            (max_reg),
    .flags              (flags),
    .last_frequency     (last_frequency),
    .position_next      (position_next),
    .idle_pos_next      (idle_next),
    .top_pos_next       (max_next),
    .flags_next         (flags_next),
    .last_frequency_next(last_frequency_next),
    .steps_moved        (steps_next),
    .status             (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      target_frequency <= '0;
    end else if (cfg_write_enable) begin
      target_frequency <= cfg_write_data;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_kind <= kind;
      req_freq <= measured_frequency;
    end
  end

  // sequencer state, updated as each request moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      position_reg   <= '0;
      idle_reg       <= '0;
      max_reg        <= '0;
      flags          <= '0;
      last_frequency <= '0;
    end else if (req_valid && advance) begin
      position_reg   <= position_next;
      idle_reg       <= idle_next;
      max_reg        <= max_next;
      flags          <= flags_next;
      last_frequency <= last_frequency_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && advance) begin
      position         <= position_next;
      steps_moved      <= steps_next;
      status           <= status_next;
      error_flag       <= flags_next.fault;
      calibrated_flag  <= flags_next.calibrated;
      calibrating_flag <= flags_next.calibrating;
    end
  end

endmodule

// File: sv/tas_checker.sv
// port-level checks for the throttle actuator sequencer, bound to the top level
module tas_checker import tas_pkg::*; #(
  parameter int POSITION_BITS = 13
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic signed [POSITION_BITS-1:0] position,
  input logic signed [POSITION_BITS:0]   steps_moved,
  input logic [STATUS_BITS-1:0]          status,
  input logic                            error_flag,
  input logic                            calibrated_flag
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(position) && $stable(steps_moved)
      && $stable(status))
    else $error("stalled result changed");

  // request side only backs up behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without a stalled result");

  // an error status (engine error or run fault) always comes with the sticky flag set
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ERROR |-> error_flag)
    else $error("engine error status without error flag");

  // uncalibrated refusals move nothing
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_UNCAL |-> steps_moved == '0 && !calibrated_flag)
    else $error("uncalibrated command moved the valve");

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind throttle_actuator_sequencer tas_checker #(
  .POSITION_BITS(POSITION_BITS)
) u_tas_checker (.*);
